// ===== src/mi3_pkg.sv =====
`timescale 1ns / 1ps

package mi3_pkg;

  // Element and result formats.
  parameter int ElemW  = 16;
  parameter int ResW   = 32;
  parameter int EFrac  = ElemW - 2;
  parameter int RFrac  = ResW / 2;
  parameter int QShift = EFrac + RFrac;

  // Internal widths.
  parameter int PrdW  = 2 * ElemW;
  parameter int AdjW  = 2 * ElemW + 1;
  parameter int AmagW = 2 * ElemW;
  parameter int DetW  = ElemW + AdjW;
  parameter int DmagW = 3 * ElemW;
  parameter int NumW  = AmagW + QShift;
  parameter int QW    = ResW + 1;
  parameter int CmpW  = DmagW + QW;

  parameter logic [QW-1:0] PosMaxQ = {{(QW-ResW+1){1'b0}}, {(ResW-1){1'b1}}};
  parameter logic [QW-1:0] NegMaxQ = {{(QW-ResW){1'b0}}, 1'b1, {(ResW-1){1'b0}}};

  // Quotient pipeline payload: one partial remainder and quotient per entry.
  typedef struct packed {
    logic [8:0][NumW-1:0] rem;
    logic [8:0][QW-1:0]   quo;
    logic [DmagW-1:0]     den;
    logic [8:0]           ovf;
    logic [8:0]           neg;
    logic                 sing;
  } div_t;

endpackage

// ===== src/mi3_divider.sv =====
`timescale 1ns / 1ps

module mi3_divider (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  mi3_pkg::div_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output mi3_pkg::div_t  data_o
);

  mi3_pkg::div_t               st_q [mi3_pkg::QW];
  logic [mi3_pkg::QW-1:0]      v_q;
  logic [mi3_pkg::QW-1:0]      adv;

  // One restoring step per stage, most significant quotient bit first.
  for (genvar s = 0; s < mi3_pkg::QW; s++) begin : g_st
    localparam int Bit = mi3_pkg::QW - 1 - s;
    mi3_pkg::div_t cur;
    mi3_pkg::div_t nxt;
    logic          vin;

    if (s == 0) begin : g_first
      assign cur = data_i;
      assign vin = valid_i;
    end else begin : g_next
      assign cur = st_q[s-1];
      assign vin = v_q[s-1];
    end

    if (s == mi3_pkg::QW - 1) begin : g_last
      assign adv[s] = !v_q[s] || ready_i;
    end else begin : g_mid
      assign adv[s] = !v_q[s] || adv[s+1];
    end

    always_comb begin
      logic [mi3_pkg::NumW-1:0] hi;
      logic [mi3_pkg::NumW-1:0] dz;
      nxt = cur;
      dz  = mi3_pkg::NumW'(cur.den);
      for (int l = 0; l < 9; l++) begin
        hi = cur.rem[l] >> Bit;
        if (hi >= dz) begin
          nxt.rem[l]      = cur.rem[l] - (dz << Bit);
          nxt.quo[l][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (adv[s]) begin
        v_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[s] && vin) begin
        st_q[s] <= nxt;
      end
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_q[mi3_pkg::QW-1];
  assign data_o  = st_q[mi3_pkg::QW-1];

endmodule

// ===== src/matrix_inverse_3x3.sv =====
`timescale 1ns / 1ps

// 3x3 matrix inverse by the adjugate method.
// The input channel (in_valid_i / in_ready_o) carries one item: a 3x3 matrix as
// nine signed Q1.14 elements m00_i..m22_i in row-major order. The output channel
// (out_valid_o / out_ready_i) carries one item per matrix: the inverse as nine
// signed Q15.16 elements r00_o..r22_o, truncated toward zero and saturated to
// 32 bits, plus singular_o. A zero determinant sets singular_o and zeroes the
// elements.
// From acceptance to out_valid_o, five stages form the products, the adjugate,
// the determinant and the divider operands, 33 stages each produce one quotient
// bit for all nine entries in parallel, and one stage saturates and holds the
// result. Throughput is one matrix per cycle while out_ready_i is high.
// Every stage has its own valid bit and loads when it is empty or when the
// stage after it moves, so a stalled receiver fills the pipeline gap by gap;
// nothing is dropped or repeated, and the input keeps being accepted until
// every stage holds an item. Reset clears all valid bits; the data registers
// are not reset.

module matrix_inverse_3x3 (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [mi3_pkg::ElemW-1:0]  m00_i,
  input  logic signed [mi3_pkg::ElemW-1:0]  m01_i,
  input  logic signed [mi3_pkg::ElemW-1:0]  m02_i,
  input  logic signed [mi3_pkg::ElemW-1:0]  m10_i,
  input  logic signed [mi3_pkg::ElemW-1:0]  m11_i,
  input  logic signed [mi3_pkg::ElemW-1:0]  m12_i,
  input  logic signed [mi3_pkg::ElemW-1:0]  m20_i,
  input  logic signed [mi3_pkg::ElemW-1:0]  m21_i,
  input  logic signed [mi3_pkg::ElemW-1:0]  m22_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [mi3_pkg::ResW-1:0]   r00_o,
  output logic signed [mi3_pkg::ResW-1:0]   r01_o,
  output logic signed [mi3_pkg::ResW-1:0]   r02_o,
  output logic signed [mi3_pkg::ResW-1:0]   r10_o,
  output logic signed [mi3_pkg::ResW-1:0]   r11_o,
  output logic signed [mi3_pkg::ResW-1:0]   r12_o,
  output logic signed [mi3_pkg::ResW-1:0]   r20_o,
  output logic signed [mi3_pkg::ResW-1:0]   r21_o,
  output logic signed [mi3_pkg::ResW-1:0]   r22_o,
  output logic                              singular_o
);

  typedef struct packed {
    logic [8:0][mi3_pkg::PrdW-1:0] pp;
    logic [8:0][mi3_pkg::PrdW-1:0] pn;
    logic [mi3_pkg::ElemW-1:0]     a;
    logic [mi3_pkg::ElemW-1:0]     b;
    logic [mi3_pkg::ElemW-1:0]     c;
  } f1_t;

  typedef struct packed {
    logic [8:0][mi3_pkg::AdjW-1:0] adj;
    logic [mi3_pkg::ElemW-1:0]     a;
    logic [mi3_pkg::ElemW-1:0]     b;
    logic [mi3_pkg::ElemW-1:0]     c;
  } f2_t;

  typedef struct packed {
    logic [2:0][mi3_pkg::DetW-1:0] dp;
    logic [8:0][mi3_pkg::AdjW-1:0] adj;
  } f3_t;

  typedef struct packed {
    logic [8:0][mi3_pkg::AmagW-1:0] amag;
    logic [mi3_pkg::DmagW-1:0]      dmag;
    logic [8:0]                     neg;
    logic                           sing;
  } f4_t;

  f1_t           f1_d, f1_q;
  f2_t           f2_d, f2_q;
  f3_t           f3_d, f3_q;
  f4_t           f4_d, f4_q;
  mi3_pkg::div_t f5_d, f5_q;
  logic          v1_q, v2_q, v3_q, v4_q, v5_q;
  logic          adv1, adv2, adv3, adv4, adv5, adv_o;

  logic          div_ready;
  logic          div_valid;
  mi3_pkg::div_t div_out;

  logic [8:0][mi3_pkg::ResW-1:0] res_d, res_q;
  logic                          sing_q;
  logic                          ov_q;

  // Each stage loads when it is empty or its successor moves on.
  assign adv_o = !ov_q || out_ready_i;
  assign adv5  = !v5_q || div_ready;
  assign adv4  = !v4_q || adv5;
  assign adv3  = !v3_q || adv4;
  assign adv2  = !v2_q || adv3;
  assign adv1  = !v1_q || adv2;
  assign in_ready_o = adv1;

  // Stage 1: the eighteen two-term products of the 2x2 minors.
  always_comb begin
    f1_d.pp[0] = m11_i * m22_i;  f1_d.pn[0] = m12_i * m21_i;
    f1_d.pp[1] = m02_i * m21_i;  f1_d.pn[1] = m01_i * m22_i;
    f1_d.pp[2] = m01_i * m12_i;  f1_d.pn[2] = m02_i * m11_i;
    f1_d.pp[3] = m12_i * m20_i;  f1_d.pn[3] = m10_i * m22_i;
    f1_d.pp[4] = m00_i * m22_i;  f1_d.pn[4] = m02_i * m20_i;
    f1_d.pp[5] = m02_i * m10_i;  f1_d.pn[5] = m00_i * m12_i;
    f1_d.pp[6] = m10_i * m21_i;  f1_d.pn[6] = m11_i * m20_i;
    f1_d.pp[7] = m20_i * m01_i;  f1_d.pn[7] = m00_i * m21_i;
    f1_d.pp[8] = m00_i * m11_i;  f1_d.pn[8] = m01_i * m10_i;
    f1_d.a = m00_i;
    f1_d.b = m01_i;
    f1_d.c = m02_i;
  end

  // Stage 2: adjugate entries, exact.
  always_comb begin
    for (int l = 0; l < 9; l++) begin
      f2_d.adj[l] = mi3_pkg::AdjW'($signed(f1_q.pp[l]))
                  - mi3_pkg::AdjW'($signed(f1_q.pn[l]));
    end
    f2_d.a = f1_q.a;
    f2_d.b = f1_q.b;
    f2_d.c = f1_q.c;
  end

  // Stage 3: first-row cofactor products of the determinant.
  always_comb begin
    f3_d.dp[0] = mi3_pkg::DetW'($signed(f2_q.a)) * mi3_pkg::DetW'($signed(f2_q.adj[0]));
    f3_d.dp[1] = mi3_pkg::DetW'($signed(f2_q.b)) * mi3_pkg::DetW'($signed(f2_q.adj[3]));
    f3_d.dp[2] = mi3_pkg::DetW'($signed(f2_q.c)) * mi3_pkg::DetW'($signed(f2_q.adj[6]));
    f3_d.adj   = f2_q.adj;
  end

  // Stage 4: determinant, magnitudes and result signs.
  always_comb begin
    logic signed [mi3_pkg::DetW-1:0] det;
    logic [mi3_pkg::DetW-1:0]        dabs;
    logic [mi3_pkg::AdjW-1:0]        aabs;
    det  = $signed(f3_q.dp[0]) + $signed(f3_q.dp[1]) + $signed(f3_q.dp[2]);
    dabs = det[mi3_pkg::DetW-1] ? (mi3_pkg::DetW'(0) - det) : det;
    f4_d.dmag = dabs[mi3_pkg::DmagW-1:0];
    f4_d.sing = (det == '0);
    for (int l = 0; l < 9; l++) begin
      aabs = f3_q.adj[l][mi3_pkg::AdjW-1] ? (mi3_pkg::AdjW'(0) - f3_q.adj[l]) : f3_q.adj[l];
      f4_d.amag[l] = aabs[mi3_pkg::AmagW-1:0];
      f4_d.neg[l]  = f3_q.adj[l][mi3_pkg::AdjW-1] ^ det[mi3_pkg::DetW-1];
    end
  end

  // Stage 5: divider operands. A quotient that does not fit the quotient
  // width is flagged here, and the saturation stage uses that flag.
  always_comb begin
    f5_d.den  = f4_q.dmag;
    f5_d.neg  = f4_q.neg;
    f5_d.sing = f4_q.sing;
    f5_d.quo  = '0;
    for (int l = 0; l < 9; l++) begin
      f5_d.rem[l] = mi3_pkg::NumW'(f4_q.amag[l]) << mi3_pkg::QShift;
      f5_d.ovf[l] = mi3_pkg::CmpW'({f4_q.amag[l], {mi3_pkg::QShift{1'b0}}})
                 >= mi3_pkg::CmpW'({f4_q.dmag, {mi3_pkg::QW{1'b0}}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
      if (adv5) v5_q <= v4_q;
      if (adv_o) ov_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) f1_q <= f1_d;
    if (adv2 && v1_q) f2_q <= f2_d;
    if (adv3 && v2_q) f3_q <= f3_d;
    if (adv4 && v3_q) f4_q <= f4_d;
    if (adv5 && v4_q) f5_q <= f5_d;
    if (adv_o && div_valid) begin
      res_q  <= res_d;
      sing_q <= div_out.sing;
    end
  end

  mi3_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .ready_o (div_ready),
    .data_i  (f5_q),
    .valid_o (div_valid),
    .ready_i (adv_o),
    .data_o  (div_out)
  );

  // Saturate, apply the sign, and force zero for a singular matrix.
  always_comb begin
    logic [mi3_pkg::QW-1:0] qs;
    logic [mi3_pkg::QW-1:0] sv;
    for (int l = 0; l < 9; l++) begin
      if (div_out.neg[l]) begin
        qs = (div_out.ovf[l] || div_out.quo[l] > mi3_pkg::NegMaxQ)
           ? mi3_pkg::NegMaxQ : div_out.quo[l];
        sv = mi3_pkg::QW'(0) - qs;
      end else begin
        qs = (div_out.ovf[l] || div_out.quo[l] > mi3_pkg::PosMaxQ)
           ? mi3_pkg::PosMaxQ : div_out.quo[l];
        sv = qs;
      end
      res_d[l] = div_out.sing ? '0 : sv[mi3_pkg::ResW-1:0];
    end
  end

  assign out_valid_o = ov_q;
  assign singular_o  = sing_q;
  assign r00_o = res_q[0];
  assign r01_o = res_q[1];
  assign r02_o = res_q[2];
  assign r10_o = res_q[3];
  assign r11_o = res_q[4];
  assign r12_o = res_q[5];
  assign r20_o = res_q[6];
  assign r21_o = res_q[7];
  assign r22_o = res_q[8];

  // A singular result always carries all-zero elements.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> res_q == '0)
    else $error("singular item with nonzero elements");

  // The singular flag matches a zero determinant magnitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (f4_q.sing == (f4_q.dmag == '0)))
    else $error("singular flag disagrees with determinant");

  // A full first stage that cannot move keeps its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !adv2 |=> v1_q && $stable(f1_q))
    else $error("stalled stage lost its item");

endmodule
